@@ rtl/prq_pkg.sv @@
// Shared types and constants of the priority ready queue.
// Used by prq_ctrl, prq_datapath and priority_ready_queue_top; depends on nothing.
`default_nettype none

package prq_pkg;

    // Table geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Item field widths
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 8;
    localparam int LIMIT_W  = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    // One table entry
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [LIMIT_W-1:0] limit;
    } entry_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                load;       // latch the request fields
        logic                write;      // append the latched entry
        logic                scan_init;  // best := entry 0, scan from entry 1
        logic                scan_step;  // compare one entry against best
        logic                shift;      // close the gap behind the best entry
        logic                emit;       // register a result
        logic [STATUS_W-1:0] code;       // status code of the result
    } prq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic req_type;
        logic full;
        logic empty;
        logic scan_done;
    } prq_stat_t;

endpackage

`default_nettype wire

@@ rtl/prq_ctrl.sv @@
// Controller of the priority ready queue: sequences insert and remove requests.
// Depends on prq_pkg; drives prq_datapath through prq_cmd_t.
`default_nettype none

module prq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire prq_pkg::prq_stat_t stat,
    output prq_pkg::prq_cmd_t      cmd,
    output logic                   busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INS   = 3'd1;
    localparam logic [2:0] ST_REM   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = prq_pkg::STATUS_INSERTED;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_INS;
                end
            end
            ST_INS:
            begin
                // request type is known once latched
                if (stat.req_type == prq_pkg::REQ_REMOVE)
                begin
                    state_next = ST_REM;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                    if (stat.full)
                    begin
                        cmd.code = prq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                        cmd.code  = prq_pkg::STATUS_INSERTED;
                    end
                end
            end
            ST_REM:
            begin
                if (stat.empty)
                begin
                    cmd.emit   = 1'b1;
                    cmd.code   = prq_pkg::STATUS_EMPTY;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                cmd.emit   = 1'b1;
                cmd.code   = prq_pkg::STATUS_REMOVED;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // A scan only runs on a non-empty table
    a_scan_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !stat.empty)
        else $error("scan on empty table");

    // Every accepted request reaches a result or a remove path
    a_ins_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_INS))
        else $error("request not decoded after load");

    // A removal result is only produced after a scan
    a_shift_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> ($past(state_reg) == ST_SCAN))
        else $error("shift without scan");

endmodule

`default_nettype wire

@@ rtl/prq_datapath.sv @@
// Datapath of the priority ready queue: entry table, fill count, best-entry scan,
// gap closing and result registers. Depends on prq_pkg; driven by prq_ctrl.
`default_nettype none

module prq_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire prq_pkg::prq_cmd_t             cmd,
    output prq_pkg::prq_stat_t                 stat,
    input  wire logic                          req_type,
    input  wire logic [prq_pkg::ID_W-1:0]      proc_id,
    input  wire logic [prq_pkg::PRIO_W-1:0]    prio,
    input  wire logic [prq_pkg::LIMIT_W-1:0]   run_limit,
    output logic                               done,
    output logic [prq_pkg::STATUS_W-1:0]       status,
    output logic [prq_pkg::ID_W-1:0]           out_id,
    output logic [prq_pkg::PRIO_W-1:0]         out_prio,
    output logic [prq_pkg::LIMIT_W-1:0]        out_limit,
    output logic [prq_pkg::OCC_W-1:0]          occupancy
);

    // Entry table in arrival order
    prq_pkg::entry_t table_reg [prq_pkg::DEPTH];

    // Latched request
    logic            req_reg;
    prq_pkg::entry_t new_reg;

    // Fill count and scan state
    logic [prq_pkg::CNT_W-1:0] fill_reg;
    logic [prq_pkg::CNT_W-1:0] fill_next;
    logic [prq_pkg::CNT_W:0]   scan_idx_reg;
    logic [prq_pkg::IDX_W-1:0] best_idx_reg;
    prq_pkg::entry_t           best_reg;
    prq_pkg::entry_t           cand;
    logic                      cand_better;

    // Result registers
    logic                         done_reg;
    logic [prq_pkg::STATUS_W-1:0] status_reg;
    prq_pkg::entry_t              out_reg;
    logic [prq_pkg::OCC_W-1:0]    occ_reg;

    // Status to the controller
    assign stat.req_type  = req_reg;
    assign stat.full      = (fill_reg == prq_pkg::CNT_W'(prq_pkg::DEPTH));
    assign stat.empty     = (fill_reg == '0);
    assign stat.scan_done = (scan_idx_reg >= {1'b0, fill_reg});

    // Candidate under scan: lower priority wins, then lower limit, else earlier
    assign cand        = table_reg[scan_idx_reg[prq_pkg::IDX_W-1:0]];
    assign cand_better = (cand.prio < best_reg.prio) ||
                         ((cand.prio == best_reg.prio) && (cand.limit < best_reg.limit));

    // Fill count update
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.write)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd.shift)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            scan_idx_reg <= '0;
            best_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= cmd.emit;
            if (cmd.scan_init)
            begin
                scan_idx_reg <= (prq_pkg::CNT_W + 1)'(1);
                best_idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (cand_better)
                begin
                    best_idx_reg <= scan_idx_reg[prq_pkg::IDX_W-1:0];
                end
            end
        end
    end

    // Request latch and best entry
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg        <= req_type;
            new_reg.id     <= proc_id;
            new_reg.prio   <= prio;
            new_reg.limit  <= run_limit;
        end
        if (cmd.scan_init)
        begin
            best_reg <= table_reg[0];
        end
        else if (cmd.scan_step && cand_better)
        begin
            best_reg <= cand;
        end
    end

    // Table: append at the fill point, or move entries behind the best up one place
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            table_reg[fill_reg[prq_pkg::IDX_W-1:0]] <= new_reg;
        end
        else if (cmd.shift)
        begin
            for (int k = 0; k < prq_pkg::DEPTH - 1; k++)
            begin
                if (prq_pkg::IDX_W'(k) >= best_idx_reg)
                begin
                    table_reg[k] <= table_reg[k + 1];
                end
            end
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg <= cmd.code;
            occ_reg    <= prq_pkg::OCC_W'(fill_next);
            if (cmd.code == prq_pkg::STATUS_REMOVED)
            begin
                out_reg <= best_reg;
            end
            else
            begin
                out_reg <= '0;
            end
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign out_id    = out_reg.id;
    assign out_prio  = out_reg.prio;
    assign out_limit = out_reg.limit;
    assign occupancy = occ_reg;

    // Fill count stays within the table
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= prq_pkg::CNT_W'(prq_pkg::DEPTH))
        else $error("fill count beyond depth");

    // A removal takes out exactly one entry
    a_shift_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |=> (fill_reg == $past(fill_reg) - 1'b1))
        else $error("removal did not decrement fill count");

    // The chosen entry lies inside the valid part of the table
    a_best_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |-> ({1'b0, best_idx_reg} < (prq_pkg::IDX_W + 1)'(fill_reg)))
        else $error("best entry outside valid range");

    // Never append into a full table
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> !stat.full)
        else $error("write into full table");

endmodule

`default_nettype wire

@@ rtl/priority_ready_queue_top.sv @@
// Priority ready queue: insert in arrival order, remove the lowest priority entry
// (ties by lower limit, then earliest). A remove scans the filled entries with one compare per
// cycle; an insert, a refused insert or a remove from an empty table runs no scan.
// busy drops in the cycle that shows done, so the next item can be taken in that cycle;
// the receiver cannot stall. Reset (rst_n low, async) empties the table, idles control.
// Depends on prq_pkg, prq_ctrl and prq_datapath.
`default_nettype none

module priority_ready_queue_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          req_type,
    input  wire logic [prq_pkg::ID_W-1:0]      proc_id,
    input  wire logic [prq_pkg::PRIO_W-1:0]    prio,
    input  wire logic [prq_pkg::LIMIT_W-1:0]   run_limit,
    output logic                               done,
    output logic [prq_pkg::STATUS_W-1:0]       status,
    output logic [prq_pkg::ID_W-1:0]           out_id,
    output logic [prq_pkg::PRIO_W-1:0]         out_prio,
    output logic [prq_pkg::LIMIT_W-1:0]        out_limit,
    output logic [prq_pkg::OCC_W-1:0]          occupancy
);

    prq_pkg::prq_cmd_t  cmd;
    prq_pkg::prq_stat_t stat;

    // Request sequencer
    prq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Table and result datapath
    prq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_type  (req_type),
        .proc_id   (proc_id),
        .prio      (prio),
        .run_limit (run_limit),
        .done      (done),
        .status    (status),
        .out_id    (out_id),
        .out_prio  (out_prio),
        .out_limit (out_limit),
        .occupancy (occupancy)
    );

endmodule

`default_nettype wire

@@ verif/priority_ready_queue_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the priority ready queue: tracks the queue contents, predicts each result.
// Compares every done strobe against the oldest prediction. Depends on prq_pkg only.

module priority_ready_queue_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         req_type,
    input  logic [prq_pkg::ID_W-1:0]     proc_id,
    input  logic [prq_pkg::PRIO_W-1:0]   prio,
    input  logic [prq_pkg::LIMIT_W-1:0]  run_limit,
    input  logic                         done,
    input  logic [prq_pkg::STATUS_W-1:0] status,
    input  logic [prq_pkg::ID_W-1:0]     out_id,
    input  logic [prq_pkg::PRIO_W-1:0]   out_prio,
    input  logic [prq_pkg::LIMIT_W-1:0]  out_limit,
    input  logic [prq_pkg::OCC_W-1:0]    occupancy,
    output int                           outstanding,
    output int                           mismatches,
    output int                           results_checked,
    output int                           refused_seen,
    output int                           empty_seen
);

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [prq_pkg::STATUS_W-1:0] status;
        logic [prq_pkg::ID_W-1:0]     id;
        logic [prq_pkg::PRIO_W-1:0]   prio;
        logic [prq_pkg::LIMIT_W-1:0]  limit;
        logic [prq_pkg::OCC_W-1:0]    occ;
    } sched_result_t;

    // Shadow copy of the ready queue, arrival order in slots 0 .. held-1
    prq_pkg::entry_t slots [prq_pkg::DEPTH];
    int              held;
    sched_result_t   pending_q [$];

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s expected %0h got %0h", $time, what, want_v, got_v);
    endtask

    // Apply one request to the shadow queue and work out the result it gives
    task automatic schedule_request(input logic req, input prq_pkg::entry_t item,
                                    output sched_result_t res);
        int best;
        res = '0;
        if (req == prq_pkg::REQ_INSERT) begin
            if (held >= prq_pkg::DEPTH) begin
                res.status = prq_pkg::STATUS_FULL;
            end
            else begin
                slots[held] = item;
                held++;
                res.status = prq_pkg::STATUS_INSERTED;
            end
        end
        else if (held == 0) begin
            res.status = prq_pkg::STATUS_EMPTY;
        end
        else begin
            // lowest priority wins, then lowest limit, then earliest arrival
            best = 0;
            for (int i = 1; i < held; i++) begin
                if (slots[i].prio < slots[best].prio ||
                    (slots[i].prio == slots[best].prio && slots[i].limit < slots[best].limit))
                    best = i;
            end
            res.status = prq_pkg::STATUS_REMOVED;
            res.id     = slots[best].id;
            res.prio   = slots[best].prio;
            res.limit  = slots[best].limit;
            // close the gap, keeping arrival order
            for (int i = best; i < held - 1; i++)
                slots[i] = slots[i + 1];
            held--;
        end
        res.occ = prq_pkg::OCC_W'(held);
    endtask

    // Compare one observed result, field by field
    task automatic compare_result(input sched_result_t want, input sched_result_t got);
        if (got.status !== want.status) report_mismatch("status", want.status, got.status);
        if (got.id !== want.id)         report_mismatch("out_id", want.id, got.id);
        if (got.prio !== want.prio)     report_mismatch("out_prio", want.prio, got.prio);
        if (got.limit !== want.limit)   report_mismatch("out_limit", want.limit, got.limit);
        if (got.occ !== want.occ)       report_mismatch("occupancy", want.occ, got.occ);
    endtask

    // Watch both channels; results are retired before the new request is predicted
    always @(posedge clk or negedge rst_n) begin
        sched_result_t   got;
        sched_result_t   want;
        prq_pkg::entry_t item;
        if (!rst_n) begin
            held = 0;
            pending_q.delete();
            outstanding = 0;
        end
        else begin
            if (done) begin
                got.status = status;
                got.id     = out_id;
                got.prio   = out_prio;
                got.limit  = out_limit;
                got.occ    = occupancy;
                if (pending_q.size() == 0) begin
                    report_mismatch("result with no request waiting, status", 0, status);
                end
                else begin
                    want = pending_q.pop_front();
                    compare_result(want, got);
                    results_checked++;
                    if (want.status == prq_pkg::STATUS_FULL) refused_seen++;
                    if (want.status == prq_pkg::STATUS_EMPTY) empty_seen++;
                end
            end
            if (start && !busy) begin
                item.id    = proc_id;
                item.prio  = prio;
                item.limit = run_limit;
                schedule_request(req_type, item, want);
                pending_q.push_back(want);
            end
            outstanding = pending_q.size();
        end
    end

endmodule

@@ verif/priority_ready_queue_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for priority_ready_queue_top: directed and random request stimulus with idling.
// Depends on prq_pkg, the block under test and priority_ready_queue_checker.

module priority_ready_queue_top_tb;

    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 24;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         req_type;
    logic [prq_pkg::ID_W-1:0]     proc_id;
    logic [prq_pkg::PRIO_W-1:0]   prio;
    logic [prq_pkg::LIMIT_W-1:0]  run_limit;
    logic                         done;
    logic [prq_pkg::STATUS_W-1:0] status;
    logic [prq_pkg::ID_W-1:0]     out_id;
    logic [prq_pkg::PRIO_W-1:0]   out_prio;
    logic [prq_pkg::LIMIT_W-1:0]  out_limit;
    logic [prq_pkg::OCC_W-1:0]    occupancy;

    int outstanding;
    int mismatches;
    int results_checked;
    int refused_seen;
    int empty_seen;

    int idle_pct     = 0;
    int inserts_sent = 0;
    int removes_sent = 0;
    int quiet_cycles = 0;

    priority_ready_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .proc_id   (proc_id),
        .prio      (prio),
        .run_limit (run_limit),
        .done      (done),
        .status    (status),
        .out_id    (out_id),
        .out_prio  (out_prio),
        .out_limit (out_limit),
        .occupancy (occupancy)
    );

    priority_ready_queue_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .proc_id         (proc_id),
        .prio            (prio),
        .run_limit       (run_limit),
        .done            (done),
        .status          (status),
        .out_id          (out_id),
        .out_prio        (out_prio),
        .out_limit       (out_limit),
        .occupancy       (occupancy),
        .outstanding     (outstanding),
        .mismatches      (mismatches),
        .results_checked (results_checked),
        .refused_seen    (refused_seen),
        .empty_seen      (empty_seen)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: ends the run after too many cycles with no handshake on either side
    always @(negedge clk)
    begin
        if (rst_n) begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Present one item, with optional idle cycles first; called at a rising edge.
    // start stays high on return so back-to-back items never toggle it.
    task automatic send_item(input logic req, input logic [prq_pkg::ID_W-1:0] id,
                             input logic [prq_pkg::PRIO_W-1:0] pr,
                             input logic [prq_pkg::LIMIT_W-1:0] lim);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= req;
        proc_id   <= id;
        prio      <= pr;
        run_limit <= lim;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        if (req == prq_pkg::REQ_INSERT)
            inserts_sent++;
        else
            removes_sent++;
    endtask

    // Hold the sender off until every predicted result has arrived
    task automatic wait_all_done();
        start <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // Random request; narrow values crowd priorities and limits to force ties
    task automatic random_item(input int insert_pct, input bit narrow);
        logic [prq_pkg::PRIO_W-1:0]  pr;
        logic [prq_pkg::LIMIT_W-1:0] lim;
        if (narrow) begin
            pr  = prq_pkg::PRIO_W'($urandom_range(3));
            lim = prq_pkg::LIMIT_W'($urandom_range(3));
        end
        else begin
            pr  = prq_pkg::PRIO_W'($urandom);
            lim = prq_pkg::LIMIT_W'($urandom);
        end
        send_item(($urandom_range(99) < insert_pct) ? prq_pkg::REQ_INSERT : prq_pkg::REQ_REMOVE,
                  prq_pkg::ID_W'($urandom), pr, lim);
    endtask

    // Stimulus
    initial
    begin
        int sent;
        int seg_len;
        int insert_pct;
        bit narrow;

        rst_n     = 1'b0;
        start     = 1'b0;
        req_type  = prq_pkg::REQ_INSERT;
        proc_id   = '0;
        prio      = '0;
        run_limit = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: remove from empty, fill with extremes and ties, refused insert, drain part
        send_item(prq_pkg::REQ_REMOVE, 8'hA5, 8'h5A, 16'hC3C3);
        send_item(prq_pkg::REQ_INSERT, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(prq_pkg::REQ_INSERT, 8'h00, 8'h00, 16'h0000);
        send_item(prq_pkg::REQ_INSERT, 8'h11, 8'h00, 16'h0000);
        for (int k = 3; k < prq_pkg::DEPTH; k++)
            send_item(prq_pkg::REQ_INSERT, prq_pkg::ID_W'(k), 8'h80,
                      prq_pkg::LIMIT_W'(k % 4));
        send_item(prq_pkg::REQ_INSERT, 8'h77, 8'h00, 16'h0000);
        repeat (7) send_item(prq_pkg::REQ_REMOVE, prq_pkg::ID_W'($urandom),
                             prq_pkg::PRIO_W'($urandom), prq_pkg::LIMIT_W'($urandom));
        wait_all_done();

        // Random phases at different sender idle rates, drained between phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1:       idle_pct = 80;
                2:       idle_pct = 32;
                default: idle_pct = 0;
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 4) begin
                seg_len = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0:       insert_pct = 80;
                    1:       insert_pct = 20;
                    default: insert_pct = 50;
                endcase
                narrow = 1'($urandom_range(1));
                for (int n = 0; n < seg_len; n++)
                    random_item(insert_pct, narrow);
                sent += seg_len;
            end
            wait_all_done();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d inserts and %0d removes over four random phases; %0d results checked.",
                 inserts_sent, removes_sent, results_checked);
        $display("Refused inserts on a full queue: %0d; removes on an empty queue: %0d.",
                 refused_seen, empty_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
